### sv/assert_macros.svh
// Assertion shorthands shared by the checker files of this block.
// Needs nothing else; each file that asserts takes it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while the reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that is also checked while the reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/siar_pkg.sv
// Shared types, constants and helper functions for the integer to ASCII unit.
// No dependencies; imported by the top level.
`default_nettype none

package siar_pkg;

   localparam int RADIX_BITS    = 6;
   localparam int DIGIT_BITS    = 6;
   localparam int CHAR_BITS     = 7;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_OCT   = 6'd8;
   localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 6'd16;
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 6'd10;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_X = 7'h58;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_SIGN = 7'b0000100,
      ST_PRE0 = 7'b0001000,
      ST_PREX = 7'b0010000,
      ST_RD   = 7'b0100000,
      ST_EMIT = 7'b1000000
   } siar_state_type;

   // Clamp the programmed base into 2..36.
   function automatic logic [RADIX_BITS-1:0] sat_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] res;
      if (d >= DIGIT_TEN) begin
         res = CHAR_UPPER_A + CHAR_BITS'(d - DIGIT_TEN);
      end else begin
         res = CHAR_ZERO + CHAR_BITS'(d);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### sv/siar_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module siar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### sv/signed_integer_to_ascii_radix_unit.sv
// Each digit is found by restoring division in ST_DIV, one quotient bit per step, and written
// to the digit store; the sign and any prefix chars leave next, then the digits, most significant first.
// Each digit is read from the digit store (ST_RD), then loaded into the output register (ST_EMIT).
// A new item is taken only in ST_IDLE, once the last char of the previous item is in the output
// register; output stalls hold the unit in its sign, prefix and digit states.
// Reset: sync, active high; clears control and output valid, radix to 10, not the digit store.
`default_nettype none

module signed_integer_to_ascii_radix_unit
   import siar_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [RADIX_BITS-1:0]                 csr_wr_data,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [((VALUE_BITS+7)/8)*8-1:0]       req_tdata,  // [VALUE_BITS-1:0] value
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [RSP_DATA_BITS-1:0]              rsp_tdata,  // [6:0] char_code
   output logic                                       rsp_tlast   // last_char
);

   localparam int CNT_BITS = $clog2(VALUE_BITS);

   siar_state_type          state_ff, state_in;
   logic [RADIX_BITS-1:0]   radix_ff, radix_in;
   logic [RADIX_BITS-1:0]   base_ff, base_in;
   logic                    neg_ff, neg_in;
   logic [VALUE_BITS-1:0]   quot_ff, quot_in;
   logic [DIGIT_BITS-1:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [CNT_BITS-1:0]     ptr_ff, ptr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]    rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    out_free;
   logic                    rsp_load;
   logic [VALUE_BITS-1:0]   value;
   logic [DIGIT_BITS:0]     trial;
   logic [DIGIT_BITS:0]     diff;
   logic                    ge;
   logic [DIGIT_BITS-1:0]   rem_step;
   logic [VALUE_BITS-1:0]   quot_step;
   logic                    last_bit;
   logic                    has_prefix;
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [DIGIT_BITS-1:0]   ram_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign value      = req_tdata[VALUE_BITS-1:0];

   // One restoring division step per cycle: quotient bits shift in at the bottom.
   assign trial     = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign diff      = trial - {1'b0, base_ff};
   assign ge        = (trial >= {1'b0, base_ff});
   assign rem_step  = ge ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
   assign quot_step = {quot_ff[VALUE_BITS-2:0], ge};
   assign last_bit  = (bit_cnt_ff == CNT_BITS'(VALUE_BITS - 1));

   assign has_prefix = (base_ff == RADIX_OCT) || (base_ff == RADIX_HEX);

   // The last digit is written on the edge that leaves ST_DIV, so the read in
   // ST_RD always sees it; write and read never meet in one cycle.
   assign ram_wr_en = (state_ff == ST_DIV) && last_bit;
   assign ram_rd_en = (state_ff == ST_RD);

   siar_ram #(
      .WIDTH (DIGIT_BITS),
      .DEPTH (VALUE_BITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (rem_step),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      radix_in    = csr_wr_en ? csr_wr_data : radix_ff;
      base_in     = base_ff;
      neg_in      = neg_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      bit_cnt_in  = bit_cnt_ff;
      ptr_in      = ptr_ff;
      rsp_load    = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               base_in    = sat_radix(radix_ff);
               neg_in     = value[VALUE_BITS-1];
               // two's complement; the most negative value maps to 2^(N-1) unsigned
               quot_in    = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
               rem_in     = '0;
               bit_cnt_in = '0;
               ptr_in     = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in    = quot_step;
            rem_in     = rem_step;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (last_bit) begin
               rem_in     = '0;
               bit_cnt_in = '0;
               if (quot_step != '0) begin
                  ptr_in = ptr_ff + 1'b1;
               end else if (neg_ff) begin
                  state_in = ST_SIGN;
               end else if (has_prefix) begin
                  state_in = ST_PRE0;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
               state_in    = has_prefix ? ST_PRE0 : ST_RD;
            end
         end
         ST_PRE0: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_char_in = CHAR_ZERO;
               rsp_last_in = 1'b0;
               state_in    = (base_ff == RADIX_HEX) ? ST_PREX : ST_RD;
            end
         end
         ST_PREX: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_char_in = CHAR_UPPER_X;
               rsp_last_in = 1'b0;
               state_in    = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_char_in = digit_to_char(ram_rd_data);
               rsp_last_in = (ptr_ff == '0);
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff - 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      ptr_ff      <= ptr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### sv/siar_checker.sv
// Port-level checks for the integer to ASCII unit, bound to its top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module siar_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled rsp item changed")

   // an accepted item makes the unit busy, moving it into its divide state
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "req_tready high straight after an accept")

   `ASSERT_CLK(a_reset_clears, clock, reset, $past(reset) |-> !rsp_tvalid && req_tready, "unit not idle after reset")

   // only sign, hex marker, decimal digits or upper-case letters may leave
   `ASSERT_CLK(a_char_set, clock, reset, rsp_tvalid |-> (rsp_tdata == 8'h2D) || (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) || (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h5A), "illegal character code")

endmodule

bind signed_integer_to_ascii_radix_unit siar_checker u_siar_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
